FILE: src/pgalloc_pkg.sv
// Package with sizes, codes and controller/datapath interface types of the page allocator.
package pgalloc_pkg;

   localparam int MAX_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;
   localparam int COUNT_BITS = 8;

   localparam int ADDR_W    = 56;
   localparam int PN_W      = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W     = $clog2(MAX_PAGES);
   localparam int DEPTH_W   = $clog2(MAX_PAGES + 1);
   localparam int CNT_W     = COUNT_BITS;
   localparam int RSP_CNT_W = 8;
   localparam int STATUS_W  = 3;
   localparam int CMD_W     = 2;

   localparam logic [ADDR_W-1:0] POOL_BASE_RST = ADDR_W'(64'h0000_0000_8000_0000);
   localparam logic [ADDR_W-1:0] POOL_TOP_RST  = ADDR_W'(64'h0000_0000_8800_0000);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_ADDREF = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_PAGES  = 3'd1,
      ST_BAD_ADDR  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic {
      CSR_POOL_BASE = 1'b0,
      CSR_POOL_TOP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic calc;
      logic index;
      logic read;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_stat_type;

endpackage

FILE: src/pgalloc_ctrl.sv
// Controller state machine that sequences the clearing pass and each item of the allocator.
module pgalloc_ctrl
   import pgalloc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_CALC,
      S_INDEX,
      S_READ,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CALC;
            end
         end
         S_CLEAR: begin
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_CALC:  state_in = S_INDEX;
         S_INDEX: state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   always_comb begin
      cmd.capture = start && (state_ff == S_IDLE);
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.calc    = (state_ff == S_CALC);
      cmd.index   = (state_ff == S_INDEX);
      cmd.read    = (state_ff == S_READ);
      cmd.exec    = (state_ff == S_EXEC);
   end

   assign busy = busy_ff;

endmodule

FILE: src/pgalloc_dpath.sv
// Datapath of the allocator: pool registers, free stack, count memory and result registers.
module pgalloc_dpath
   import pgalloc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_stat_type          stat,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [ADDR_W-1:0]    req_phys_addr,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_page_addr,
   output logic                 rsp_is_single,
   output logic                 rsp_page_released,
   output logic [RSP_CNT_W-1:0] rsp_ref_count
);

   localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
   localparam logic [CNT_W-1:0]   COUNT_ONE   = CNT_W'(1);
   localparam logic [DEPTH_W-1:0] MAX_PAGES_D = DEPTH_W'(MAX_PAGES);
   localparam logic [PN_W-1:0]    MAX_PAGES_P = PN_W'(MAX_PAGES);
   localparam logic [IDX_W-1:0]   CLR_LAST    = IDX_W'(MAX_PAGES - 1);

   logic [CNT_W-1:0] count_mem_ff [MAX_PAGES];
   logic [IDX_W-1:0] stack_mem_ff [MAX_PAGES];

   logic [ADDR_W-1:0]  pool_base_ff, pool_top_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0]   clr_addr_ff;
   logic               rsp_valid_ff;

   cmd_type            cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [DEPTH_W-1:0] n_ff, n_in;
   logic [PN_W-1:0]    offset_ff;
   logic               below_ff, unaligned_ff;
   logic [IDX_W-1:0]   stack_rd_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               page_ok_ff, page_ok_in;
   logic               pop_ff, pop_in;
   logic [CNT_W-1:0]   cnt_rd_ff;

   status_type          status_in;
   logic [ADDR_W-1:0]   page_addr_in;
   logic                single_in, released_in;
   logic [CNT_W-1:0]    count_in;
   status_type          rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_page_addr_ff;
   logic                rsp_single_ff, rsp_released_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [PN_W-1:0]    base_pn, top_pn, addr_pn, pa_pn;
   logic [PN_W:0]      span, offset;
   logic [DEPTH_W-1:0] depth_dec, fresh_idx;
   logic               in_pool, have_stack, have_fresh;
   logic               cnt_we, push;
   logic [CNT_W-1:0]   cnt_wd, cnt_dec, cnt_inc;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [CNT_W-1:0]   mem_wdata;
   logic [RSP_CNT_W+CNT_W-1:0] count_ext;

   assign base_pn = pool_base_ff[ADDR_W-1:PAGE_SHIFT];
   assign top_pn  = pool_top_ff[ADDR_W-1:PAGE_SHIFT];
   assign addr_pn = addr_ff[ADDR_W-1:PAGE_SHIFT];

   // Pool size and page offset of the request.
   always_comb begin
      span   = {1'b0, top_pn} - {1'b0, base_pn};
      offset = {1'b0, addr_pn} - {1'b0, base_pn};
      if (span[PN_W]) begin
         n_in = '0;
      end else if (span[PN_W-1:0] > MAX_PAGES_P) begin
         n_in = MAX_PAGES_D;
      end else begin
         n_in = span[DEPTH_W-1:0];
      end
   end

   // Page selection.
   always_comb begin
      depth_dec  = depth_ff - DEPTH_W'(1);
      fresh_idx  = n_ff - DEPTH_W'(1) - fresh_ff;
      in_pool    = !below_ff && (offset_ff < {{(PN_W-DEPTH_W){1'b0}}, n_ff});
      have_stack = (depth_ff != '0);
      have_fresh = (fresh_ff < n_ff);
      if (cmd_ff == CMD_ALLOC) begin
         pop_in     = have_stack;
         page_ok_in = have_stack || have_fresh;
         idx_in     = have_stack ? stack_rd_ff : fresh_idx[IDX_W-1:0];
      end else begin
         pop_in     = 1'b0;
         page_ok_in = in_pool;
         idx_in     = offset_ff[IDX_W-1:0];
      end
   end

   // Result and state update of one item.
   always_comb begin
      status_in    = ST_OK;
      page_addr_in = '0;
      single_in    = 1'b0;
      released_in  = 1'b0;
      count_in     = '0;
      cnt_we       = 1'b0;
      cnt_wd       = COUNT_ONE;
      push         = 1'b0;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      cnt_dec      = cnt_rd_ff - COUNT_ONE;
      cnt_inc      = cnt_rd_ff + COUNT_ONE;
      pa_pn        = base_pn + {{(PN_W-IDX_W){1'b0}}, idx_ff};
      unique case (cmd_ff)
         CMD_ALLOC: begin
            if (page_ok_ff) begin
               cnt_we       = 1'b1;
               page_addr_in = {pa_pn, {PAGE_SHIFT{1'b0}}};
               single_in    = 1'b1;
               count_in     = COUNT_ONE;
               if (pop_ff) begin
                  depth_in = depth_dec;
               end else begin
                  fresh_in = fresh_ff + DEPTH_W'(1);
               end
            end else begin
               status_in = ST_NO_PAGES;
            end
         end
         CMD_FREE: begin
            if (unaligned_ff || !page_ok_ff) begin
               status_in = ST_BAD_ADDR;
            end else if (cnt_rd_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               cnt_we    = 1'b1;
               cnt_wd    = cnt_dec;
               count_in  = cnt_dec;
               single_in = (cnt_dec == COUNT_ONE);
               if (cnt_dec == '0) begin
                  released_in = 1'b1;
                  if (depth_ff < MAX_PAGES_D) begin
                     push     = 1'b1;
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end
            end
         end
         CMD_ADDREF: begin
            if (!page_ok_ff || (cnt_rd_ff == '0)) begin
               status_in = ST_BAD_ADDR;
            end else if (cnt_rd_ff == COUNT_MAX) begin
               status_in = ST_OVERFLOW;
               count_in  = cnt_rd_ff;
               single_in = (cnt_rd_ff == COUNT_ONE);
            end else begin
               cnt_we    = 1'b1;
               cnt_wd    = cnt_inc;
               count_in  = cnt_inc;
               single_in = (cnt_inc == COUNT_ONE);
            end
         end
         CMD_QUERY: begin
            if (!page_ok_ff) begin
               status_in = ST_BAD_ADDR;
            end else begin
               count_in  = cnt_rd_ff;
               single_in = (cnt_rd_ff == COUNT_ONE);
            end
         end
         default: status_in = ST_BAD_ADDR;
      endcase
   end

   assign mem_we    = cmd.clear || (cmd.exec && cnt_we);
   assign mem_waddr = cmd.clear ? clr_addr_ff : idx_ff;
   assign mem_wdata = cmd.clear ? '0 : cnt_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         cnt_rd_ff <= count_mem_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push) begin
         stack_mem_ff[depth_ff[IDX_W-1:0]] <= idx_ff;
      end
      if (cmd.calc) begin
         stack_rd_ff <= stack_mem_ff[depth_dec[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RST;
         pool_top_ff  <= POOL_TOP_RST;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_POOL_BASE: pool_base_ff <= csr_wdata;
               CSR_POOL_TOP:  pool_top_ff  <= csr_wdata;
               default:       pool_top_ff  <= csr_wdata;
            endcase
         end
         if (cmd.exec) begin
            depth_ff <= depth_in;
            fresh_ff <= fresh_in;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         addr_ff <= req_phys_addr;
      end
      if (cmd.calc) begin
         n_ff         <= n_in;
         offset_ff    <= offset[PN_W-1:0];
         below_ff     <= offset[PN_W];
         unaligned_ff <= |addr_ff[PAGE_SHIFT-1:0];
      end
      if (cmd.index) begin
         idx_ff     <= idx_in;
         page_ok_ff <= page_ok_in;
         pop_ff     <= pop_in;
      end
      if (cmd.exec) begin
         rsp_status_ff    <= status_in;
         rsp_page_addr_ff <= page_addr_in;
         rsp_single_ff    <= single_in;
         rsp_released_ff  <= released_in;
         rsp_count_ff     <= count_in;
      end
   end

   assign stat.clear_done = cmd.clear && (clr_addr_ff == CLR_LAST);

   assign count_ext         = {{RSP_CNT_W{1'b0}}, rsp_count_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_addr     = rsp_page_addr_ff;
   assign rsp_is_single     = rsp_single_ff;
   assign rsp_page_released = rsp_released_ff;
   assign rsp_ref_count     = count_ext[RSP_CNT_W-1:0];

endmodule

FILE: src/page_allocator_refcount_top.sv
// Top level of the physical page allocator with per-page reference counts.
//
// An item is a command (alloc, free, add reference, query single) with a page address.
// It is accepted at a rising edge where start is high and busy is low. Each item gives
// exactly one result on the rsp_ ports, marked by rsp_valid for one cycle; the receiver
// cannot stall, so the result must be taken in that cycle.
// An accepted item passes through the states calc, index, read and exec, which come from
// the registered reads of the free stack and of the count memory in series ahead of the
// read-modify-write. Its result shows in the cycle after exec, and busy falls in that
// same cycle; the next item can be accepted at the end of the result cycle.
// The pool registers are written through csr_we, csr_index and csr_wdata; the user must
// do so only while busy is low and no result is pending, as the block does not enforce it.
// After reset, busy stays high for a clearing pass that zeroes all 32768 count entries,
// one entry per cycle; the free stack is empty and no page has been handed out.
module page_allocator_refcount_top
   import pgalloc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [ADDR_W-1:0]    req_phys_addr,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_page_addr,
   output logic                 rsp_is_single,
   output logic                 rsp_page_released,
   output logic [RSP_CNT_W-1:0] rsp_ref_count
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   pgalloc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pgalloc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_cmd           (req_cmd),
      .req_phys_addr     (req_phys_addr),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_page_addr     (rsp_page_addr),
      .rsp_is_single     (rsp_is_single),
      .rsp_page_released (rsp_page_released),
      .rsp_ref_count     (rsp_ref_count)
   );

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the block is busy");

   a_item_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted item gave no result after five cycles");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_page_addr == '0) && !rsp_page_released)
      else $error("failed item carries a page address or a release");

   a_release_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_released) |-> (rsp_ref_count == '0) && (rsp_status == ST_OK))
      else $error("released page with nonzero count");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the page allocator with per-page reference counts.
`timescale 1ns / 1ps

module tb;
   import pgalloc_pkg::*;

   localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 1);
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX = '1;
   localparam int unsigned       CYCLE_LIMIT = 400000;

   typedef struct {
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
   } page_cmd_type;

   typedef struct {
      status_type           status;
      logic [ADDR_W-1:0]    page_addr;
      logic                 single;
      logic                 released;
      logic [RSP_CNT_W-1:0] count;
   } page_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [ADDR_W-1:0]    req_phys_addr = '0;
   logic                 csr_we = 1'b0;
   logic                 csr_index = 1'b0;
   logic [ADDR_W-1:0]    csr_wdata = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_page_addr;
   logic                 rsp_is_single;
   logic                 rsp_page_released;
   logic [RSP_CNT_W-1:0] rsp_ref_count;

   // Shadow copy of the allocator state.
   logic [ADDR_W-1:0] cfg_base = POOL_BASE_RST;
   logic [ADDR_W-1:0] cfg_top = POOL_TOP_RST;
   logic [CNT_W-1:0]  count_of [MAX_PAGES];
   logic [IDX_W-1:0]  stack_mem [MAX_PAGES];
   int unsigned       stack_top = 0;
   int unsigned       fresh_count = 0;

   // Pages believed to be out, used to aim the random commands.
   bit                on_hold [MAX_PAGES];
   int unsigned       held_pages [$];

   page_cmd_type      cmd_backlog [$];
   page_result_type   awaited_results [$];
   page_cmd_type      in_flight;
   int unsigned       gap_left = 0;
   bit                no_gaps = 1'b0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   page_allocator_refcount_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_phys_addr     (req_phys_addr),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_page_addr     (rsp_page_addr),
      .rsp_is_single     (rsp_is_single),
      .rsp_page_released (rsp_page_released),
      .rsp_ref_count     (rsp_ref_count)
   );

   always #4 clock = ~clock;

   function automatic int unsigned pool_pages();
      logic [ADDR_W-1:0] b, t, d;
      b = cfg_base & ~OFFSET_MASK;
      t = cfg_top & ~OFFSET_MASK;
      if (t <= b) return 0;
      d = (t - b) >> PAGE_SHIFT;
      if (d > MAX_PAGES) return MAX_PAGES;
      return int'(d);
   endfunction

   function automatic bit pool_index(input logic [ADDR_W-1:0] addr, output int unsigned idx);
      logic [ADDR_W-1:0] b, a, d;
      b = cfg_base & ~OFFSET_MASK;
      a = addr & ~OFFSET_MASK;
      idx = 0;
      if (a < b) return 1'b0;
      d = (a - b) >> PAGE_SHIFT;
      if (d >= pool_pages()) return 1'b0;
      idx = int'(d);
      return 1'b1;
   endfunction

   function automatic page_result_type page_result_for(input page_cmd_type c);
      page_result_type r;
      int unsigned     n, idx;
      bit              got;
      r.status = ST_OK;
      r.page_addr = '0;
      r.single = 1'b0;
      r.released = 1'b0;
      r.count = '0;
      n = pool_pages();
      idx = 0;
      got = 1'b0;
      case (c.cmd)
         CMD_ALLOC: begin
            if (stack_top > 0) begin
               stack_top--;
               idx = stack_mem[stack_top];
               got = 1'b1;
            end else if (fresh_count < n) begin
               idx = n - 1 - fresh_count;
               fresh_count++;
               got = 1'b1;
            end
            if (got) begin
               count_of[idx] = CNT_W'(1);
               r.page_addr = (cfg_base & ~OFFSET_MASK) + (ADDR_W'(idx) << PAGE_SHIFT);
               r.single = 1'b1;
               r.count = RSP_CNT_W'(1);
               if (!on_hold[idx]) begin
                  on_hold[idx] = 1'b1;
                  held_pages.push_back(idx);
               end
            end else begin
               r.status = ST_NO_PAGES;
            end
         end
         CMD_FREE: begin
            if ((c.addr & OFFSET_MASK) != 0 || !pool_index(c.addr, idx)) begin
               r.status = ST_BAD_ADDR;
            end else if (count_of[idx] == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               count_of[idx]--;
               r.count = RSP_CNT_W'(count_of[idx]);
               r.single = (count_of[idx] == 1);
               if (count_of[idx] == 0) begin
                  if (stack_top < MAX_PAGES) begin
                     stack_mem[stack_top] = IDX_W'(idx);
                     stack_top++;
                  end
                  r.released = 1'b1;
                  on_hold[idx] = 1'b0;
                  for (int k = 0; k < held_pages.size(); k++) begin
                     if (held_pages[k] == idx) begin
                        held_pages.delete(k);
                        break;
                     end
                  end
               end
            end
         end
         CMD_ADDREF: begin
            if (!pool_index(c.addr, idx) || count_of[idx] == 0) begin
               r.status = ST_BAD_ADDR;
            end else begin
               if (count_of[idx] >= CNT_MAX) begin
                  r.status = ST_OVERFLOW;
               end else begin
                  count_of[idx]++;
               end
               r.count = RSP_CNT_W'(count_of[idx]);
               r.single = (count_of[idx] == 1);
            end
         end
         default: begin
            if (!pool_index(c.addr, idx)) begin
               r.status = ST_BAD_ADDR;
            end else begin
               r.count = RSP_CNT_W'(count_of[idx]);
               r.single = (count_of[idx] == 1);
            end
         end
      endcase
      return r;
   endfunction

   function automatic page_cmd_type random_request(input int unsigned alloc_pct);
      page_cmd_type      c;
      int unsigned       n, idx, pick;
      logic [ADDR_W-1:0] base_al;
      n = pool_pages();
      base_al = cfg_base & ~OFFSET_MASK;
      if ($urandom_range(99) < alloc_pct) c.cmd = CMD_ALLOC;
      else c.cmd = cmd_type'($urandom_range(1, 3));
      pick = $urandom_range(99);
      if (pick < 55 && held_pages.size() != 0) begin
         idx = held_pages[$urandom_range(held_pages.size() - 1)];
      end else if (n != 0) begin
         idx = n - 1 - $urandom_range((n < 12 ? n : 12) - 1);
      end else begin
         idx = $urandom_range(7);
      end
      c.addr = base_al + (ADDR_W'(idx) << PAGE_SHIFT);
      pick = $urandom_range(99);
      if (c.cmd == CMD_ALLOC || pick < 12) begin
         c.addr = ADDR_W'({$urandom, $urandom});
      end else if (pick < 22) begin
         c.addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
      end
      return c;
   endfunction

   task automatic queue_cmd(input cmd_type cmd, input logic [ADDR_W-1:0] addr);
      page_cmd_type c;
      c.cmd = cmd;
      c.addr = addr;
      cmd_backlog.push_back(c);
   endtask

   task automatic settle();
      while (cmd_backlog.size() != 0 || start || busy || awaited_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_POOL_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_POOL_TOP;
      csr_wdata <= top;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_base = base;
      cfg_top = top;
   endtask

   task automatic random_phase(input int unsigned items);
      int unsigned alloc_pct;
      alloc_pct = 30;
      for (int unsigned k = 0; k < items; k++) begin
         if (k % 16 == 0) alloc_pct = $urandom_range(5, 60);
         while (cmd_backlog.size() > 1) @(posedge clock);
         cmd_backlog.push_back(random_request(alloc_pct));
      end
   endtask

   // Driver: holds an item until it is taken, then idles at random or sends the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) awaited_results.push_back(page_result_for(in_flight));
         if (!start || !busy) begin
            if (cmd_backlog.size() != 0 && gap_left == 0 &&
                (no_gaps || $urandom_range(99) >= 37)) begin
               in_flight = cmd_backlog.pop_front();
               start <= 1'b1;
               req_cmd <= in_flight.cmd;
               req_phys_addr <= in_flight.addr;
            end else begin
               if (gap_left != 0) gap_left--;
               else if (cmd_backlog.size() != 0) gap_left = $urandom_range(5);
               start <= 1'b0;
               req_cmd <= CMD_W'($urandom);
               req_phys_addr <= ADDR_W'({$urandom, $urandom});
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      page_result_type want, got;
      if (!reset && rsp_valid === 1'b1) begin
         got.status = status_type'(rsp_status);
         got.page_addr = rsp_page_addr;
         got.single = rsp_is_single;
         got.released = rsp_page_released;
         got.count = rsp_ref_count;
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result with none expected: status %0d page %h", rsp_status,
                        rsp_page_addr);
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.page_addr !== want.page_addr ||
                got.single !== want.single || got.released !== want.released ||
                got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected status %0d page %h single %0d released %0d count %0d",
                           want.status, want.page_addr, want.single, want.released,
                           want.count);
                  $display("          got status %0d page %h single %0d released %0d count %0d",
                           rsp_status, rsp_page_addr, rsp_is_single, rsp_page_released,
                           rsp_ref_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] page0, base;
      foreach (count_of[k]) count_of[k] = '0;
      foreach (on_hold[k]) on_hold[k] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Untouched pages, addresses around the pool and unaligned forms at the reset pool.
      queue_cmd(CMD_QUERY, 56'h0000_0080_000000);
      queue_cmd(CMD_FREE, 56'h0000_0080_000000);
      queue_cmd(CMD_ADDREF, 56'h0000_0080_000000);
      queue_cmd(CMD_QUERY, 56'h0000_007F_FFFFFF);
      queue_cmd(CMD_QUERY, 56'h0000_0088_000000);
      queue_cmd(CMD_ADDREF, ALL_ONES);
      queue_cmd(CMD_FREE, '0);
      queue_cmd(CMD_FREE, 56'h0000_0080_000800);
      queue_cmd(CMD_QUERY, 56'h0000_0087_FFFFFF);

      // A pool of one page, with an unaligned base.
      page0 = 56'hAB_CDEF_0000_0000;
      write_pool(page0 | 56'hFFF, page0 + 56'h17FF);
      queue_cmd(CMD_ALLOC, ALL_ONES);
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_QUERY, page0 + 56'h123);
      queue_cmd(CMD_ADDREF, page0 + 56'hFFF);
      queue_cmd(CMD_FREE, page0);
      queue_cmd(CMD_FREE, page0 + 56'h1000);
      queue_cmd(CMD_FREE, page0);
      queue_cmd(CMD_FREE, page0);
      queue_cmd(CMD_ADDREF, page0);
      queue_cmd(CMD_ALLOC, '0);
      // Drive the count into saturation, then back down a little.
      repeat (262) queue_cmd(CMD_ADDREF, page0);
      repeat (12) queue_cmd(CMD_FREE, page0);
      random_phase(40);

      // Empty pools: top below base at the extremes, then top equal to base.
      write_pool(ALL_ONES, '0);
      random_phase(25);
      write_pool(56'h00_0000_1234_5000, 56'h00_0000_1234_5000);
      random_phase(25);

      // Seven pages at the very top of the address space.
      write_pool(56'hFF_FFFF_FFFF_8123, ALL_ONES);
      random_phase(280);

      // Twenty-four pages at a random place.
      base = ADDR_W'({$urandom, $urandom}) & (ALL_ONES >> 1);
      write_pool(base, (base & ~OFFSET_MASK) + 56'd24 * 56'h1000 + ADDR_W'($urandom_range(4095)));
      random_phase(280);

      // The whole address range, clamped to the largest pool, with no idle cycles.
      write_pool('0, ALL_ONES);
      no_gaps = 1'b1;
      random_phase(250);
      settle();
      no_gaps = 1'b0;

      write_pool(POOL_BASE_RST, POOL_TOP_RST);
      random_phase(200);
      settle();

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
